/* design/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The antecedent implies the consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* design/rca_pkg.sv */
`default_nettype none
package rca_pkg;
    localparam int CW    = 8;
    localparam int PW    = 25;
    localparam int RW    = 17;
    localparam int NW    = 18;
    localparam int FW    = 10;
    localparam int NCELL = PW;

    localparam logic signed [FW-1:0] FACT_MIN = -10'sd255;
    localparam logic signed [FW-1:0] FACT_MAX = 10'sd259;
    localparam logic [NW-1:0] NUM_RESET = 18'd73815;
    localparam logic [RW-1:0] DEN_RESET = 17'd58395;
    localparam logic [NW-1:0] NUM_MAX   = 18'd133126;
    localparam logic [CW-1:0] MID       = 8'd128;
    localparam logic [CW-1:0] CMAX      = 8'd255;

    typedef struct packed {
        logic          neg;
        logic [RW-1:0] rem;
        logic [PW-1:0] dq;
    } lane_t;

    typedef struct packed {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
        logic [CW-1:0] alpha;
        lane_t [2:0]   lane;
    } stage_t;
endpackage
`default_nettype wire

/* design/rca_if.sv */
`default_nettype none
interface rca_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rca_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface
`default_nettype wire

/* design/rca_mul.sv */
`default_nettype none
module rca_mul (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   valid_in,
    input  wire logic [rca_pkg::CW-1:0] red,
    input  wire logic [rca_pkg::CW-1:0] green,
    input  wire logic [rca_pkg::CW-1:0] blue,
    input  wire logic [rca_pkg::CW-1:0] alpha,
    input  wire logic [rca_pkg::NW-1:0] num,
    output logic                        valid_out,
    output rca_pkg::stage_t             stage_out
);
    import rca_pkg::*;

    logic            valid_reg;
    stage_t          stage_reg;
    stage_t          stage_next;
    logic [CW-1:0]   chan [3];
    logic [CW-1:0]   mag  [3];
    logic [PW+CW:0]  prod [3];

    assign chan[0] = red;
    assign chan[1] = green;
    assign chan[2] = blue;

    always_comb
    begin
        stage_next       = '0;
        stage_next.red   = red;
        stage_next.green = green;
        stage_next.blue  = blue;
        stage_next.alpha = alpha;
        for (int i = 0; i < 3; i++)
        begin
            mag[i]  = chan[i][CW-1] ? (chan[i] - MID) : (MID - chan[i]);
            prod[i] = {{(PW-NW+1){1'b0}}, num} * {{(PW+1){1'b0}}, mag[i]};
            stage_next.lane[i].neg = !chan[i][CW-1];
            stage_next.lane[i].dq  = prod[i][PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;
endmodule
`default_nettype wire

/* design/rca_cell.sv */
`default_nettype none
module rca_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic [rca_pkg::RW-1:0] den,
    input  wire logic                   valid_in,
    input  wire rca_pkg::stage_t        stage_in,
    output logic                        valid_out,
    output rca_pkg::stage_t             stage_out
);
    import rca_pkg::*;

    logic          valid_reg;
    stage_t        stage_reg;
    stage_t        stage_next;
    logic [RW:0]   trial [3];
    logic [RW:0]   diff  [3];

    // One restoring division step per lane: one quotient bit per cell.
    always_comb
    begin
        stage_next = stage_in;
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {stage_in.lane[i].rem, stage_in.lane[i].dq[PW-1]};
            diff[i]  = trial[i] - {1'b0, den};
            if (trial[i] >= {1'b0, den})
            begin
                stage_next.lane[i].rem = diff[i][RW-1:0];
                stage_next.lane[i].dq  = {stage_in.lane[i].dq[PW-2:0], 1'b1};
            end
            else
            begin
                stage_next.lane[i].rem = trial[i][RW-1:0];
                stage_next.lane[i].dq  = {stage_in.lane[i].dq[PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;
endmodule
`default_nettype wire

/* design/rca_clamp.sv */
`default_nettype none
module rca_clamp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             valid_in,
    input  wire rca_pkg::stage_t  stage_in,
    output logic                  valid_out,
    output logic [4*rca_pkg::CW-1:0] pix_out
);
    import rca_pkg::*;

    logic              valid_reg;
    logic [4*CW-1:0]   pix_reg;
    logic [4*CW-1:0]   pix_next;
    logic [CW-1:0]     chan [3];
    logic [CW-1:0]     orig [3];
    logic [PW-1:0]     q;

    assign orig[0] = stage_in.red;
    assign orig[1] = stage_in.green;
    assign orig[2] = stage_in.blue;

    always_comb
    begin
        q = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = stage_in.lane[i].dq;
            if (stage_in.alpha == '0)
            begin
                chan[i] = orig[i];
            end
            else if (stage_in.lane[i].neg)
            begin
                chan[i] = (q > PW'(MID)) ? '0 : CW'(PW'(MID) - q);
            end
            else
            begin
                chan[i] = (q > PW'(CMAX - MID)) ? CMAX : CW'(PW'(MID) + q);
            end
        end
        pix_next = {stage_in.alpha, chan[2], chan[1], chan[0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg <= pix_next;
        end
    end

    assign valid_out = valid_reg;
    assign pix_out   = pix_reg;
endmodule
`default_nettype wire

/* design/rgba_contrast_adjust.sv */
// Contrast correction of an RGBA pixel stream. One pixel is taken per clock
// while ready is high, and each color channel becomes clamp((c - 128) * num /
// den + 128) with the quotient truncated toward zero; alpha passes through, and
// a pixel with zero alpha leaves unchanged. The factor register is saturated to
// -255..259 and turned into num and den when written, which must happen while no
// pixel is in flight. A pixel passes one multiply stage, a row of 25 cells that
// each produce one quotient bit for all three channels, and the clamp stage,
// which is also the output register. The whole row advances whenever the output
// register is empty or being drained, so ready follows the output side directly.
`default_nettype none
`include "assert_macros.svh"
module rgba_contrast_adjust (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [rca_pkg::FW-1:0] cfg_wdata,
    rca_in_if.sink                      pix_in,
    rca_out_if.source                   pix_out
);
    import rca_pkg::*;

    logic [NW-1:0]          num_reg;
    logic [NW-1:0]          num_next;
    logic [RW-1:0]          den_reg;
    logic [RW-1:0]          den_next;
    logic signed [FW-1:0]   fsat;
    logic [FW-1:0]          up;
    logic [FW-1:0]          dn;
    logic                   en;
    logic                   valid_c [NCELL+1];
    stage_t                 stage_c [NCELL+1];
    logic                   valid_o;
    logic [4*CW-1:0]        pix_o;

    always_comb
    begin
        if ($signed(cfg_wdata) < FACT_MIN)
        begin
            fsat = FACT_MIN;
        end
        else if ($signed(cfg_wdata) > FACT_MAX)
        begin
            fsat = FACT_MAX;
        end
        else
        begin
            fsat = $signed(cfg_wdata);
        end
        up       = FW'(fsat - FACT_MIN);
        dn       = FW'(FACT_MAX - fsat);
        num_next = NW'({{(NW-FW){1'b0}}, up} * NW'(259));
        den_next = (fsat == FACT_MAX) ? RW'(1) : RW'({{(RW-FW){1'b0}}, dn} * RW'(255));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= NUM_RESET;
            den_reg <= DEN_RESET;
        end
        else if (cfg_we)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign en           = !valid_o || pix_out.ready;
    assign pix_in.ready = en;

    rca_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (pix_in.valid),
        .red       (pix_in.red_in),
        .green     (pix_in.green_in),
        .blue      (pix_in.blue_in),
        .alpha     (pix_in.alpha_in),
        .num       (num_reg),
        .valid_out (valid_c[0]),
        .stage_out (stage_c[0])
    );

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        rca_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .den       (den_reg),
            .valid_in  (valid_c[k]),
            .stage_in  (stage_c[k]),
            .valid_out (valid_c[k+1]),
            .stage_out (stage_c[k+1])
        );
    end

    rca_clamp u_clamp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (valid_c[NCELL]),
        .stage_in  (stage_c[NCELL]),
        .valid_out (valid_o),
        .pix_out   (pix_o)
    );

    assign pix_out.valid     = valid_o;
    assign pix_out.red_out   = pix_o[CW-1:0];
    assign pix_out.green_out = pix_o[2*CW-1:CW];
    assign pix_out.blue_out  = pix_o[3*CW-1:2*CW];
    assign pix_out.alpha_out = pix_o[4*CW-1:3*CW];

    `ASSERT_ALWAYS(a_den_nonzero, clk, rst_n, den_reg != '0, "divisor is zero")
    `ASSERT_ALWAYS(a_num_range, clk, rst_n, num_reg <= NUM_MAX, "numerator out of range")
    `ASSERT_IMPLIES(a_ready_drain, clk, rst_n, pix_out.valid && !pix_out.ready,
        !pix_in.ready, "input taken while output is stalled")
endmodule
`default_nettype wire

/* dv/rgba_contrast_adjust_tb.sv */
`timescale 1ns / 1ps
module rgba_contrast_adjust_tb;
    import rca_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    localparam int PIPE_DEPTH = 27;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [FW-1:0] cfg_wdata = '0;

    rca_in_if pix_in ();
    rca_out_if pix_out ();

    rgba_contrast_adjust dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .pix_in   (pix_in.sink),
        .pix_out  (pix_out.source)
    );

    pixel_t expected_pixels[$];
    int factor_now = 30;
    int errors = 0;
    int sent = 0;
    int received = 0;
    int factors_used = 0;
    int hold_cycles = 0;
    bit sink_random = 1'b1;

    initial pix_in.valid = 1'b0;
    initial pix_in.red_in = '0;
    initial pix_in.green_in = '0;
    initial pix_in.blue_in = '0;
    initial pix_in.alpha_in = '0;
    initial pix_out.ready = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] contrast_channel(logic [7:0] c, int f);
        longint num;
        longint den;
        longint v;
        num = 259 * (f + 255);
        den = 255 * (259 - f);
        if (den == 0)
            den = 1;
        v = (longint'(c) - 128) * num / den + 128;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    function automatic pixel_t contrast_pixel(pixel_t p);
        pixel_t r;
        r = p;
        if (p.alpha != 0)
        begin
            r.red = contrast_channel(p.red, factor_now);
            r.green = contrast_channel(p.green, factor_now);
            r.blue = contrast_channel(p.blue, factor_now);
        end
        return r;
    endfunction

    // Valid stays high after a transfer so that back-to-back items need no
    // second assignment in the same time step; idle gaps and drains drop it.
    task automatic send_pixel(pixel_t p);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.red_in <= p.red;
        pix_in.green_in <= p.green;
        pix_in.blue_in <= p.blue;
        pix_in.alpha_in <= p.alpha;
        do
            @(posedge clk);
        while (!pix_in.ready);
        expected_pixels.push_back(contrast_pixel(p));
        sent++;
    endtask

    task automatic drain_pipe();
        pix_in.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic write_factor(logic [FW-1:0] value);
        int v;
        drain_pipe();
        v = $signed(value);
        if (v < -255)
            v = -255;
        if (v > 259)
            v = 259;
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        factor_now = v;
        factors_used++;
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = $urandom;
        if ($urandom_range(0, 9) == 0)
            p.alpha = 0;
        return p;
    endfunction

    task automatic test_extremes();
        pixel_t p;
        p = '{8'd0, 8'd255, 8'd128, 8'd255};
        send_pixel(p);
        p = '{8'd255, 8'd0, 8'd127, 8'd1};
        send_pixel(p);
        p = '{8'd129, 8'd1, 8'd254, 8'd128};
        send_pixel(p);
        p = '{8'd200, 8'd50, 8'd100, 8'd0};
        send_pixel(p);
        p = '{8'd0, 8'd255, 8'd128, 8'd0};
        send_pixel(p);
    endtask

    task automatic test_factor_settings();
        logic [FW-1:0] settings[9];
        settings = '{10'sd259, -10'sd255, 10'sd0, 10'h200, 10'sd511,
                     10'sd258, -10'sd254, 10'sd128, 10'sd30};
        foreach (settings[i])
        begin
            write_factor(settings[i]);
            test_extremes();
        end
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 10; phase++)
        begin
            write_factor(phase == 0 ? 10'($urandom_range(0, 1023))
                                    : 10'($urandom_range(0, 1023)));
            for (int i = 0; i < 110; i++)
                send_pixel(random_pixel());
        end
    endtask

    task automatic test_backpressure();
        write_factor(-10'sd100);
        fork
            begin
                sink_random = 1'b0;
                hold_cycles = 0;
                while (hold_cycles < 120)
                begin
                    @(posedge clk);
                    hold_cycles++;
                end
                sink_random = 1'b1;
            end
            begin
                for (int i = 0; i < 80; i++)
                    send_pixel(random_pixel());
            end
        join
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || !sink_random)
            pix_out.ready <= 1'b0;
        else
            pix_out.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 99) < 20);
    end

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && pix_out.valid && pix_out.ready)
        begin
            got = '{pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                    pix_out.alpha_out};
            received++;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected transfer, actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red)
                begin
                    $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
                    errors++;
                end
                if (got.green !== want.green)
                begin
                    $display("%0t: green expected %0d actual %0d", $time, want.green,
                             got.green);
                    errors++;
                end
                if (got.blue !== want.blue)
                begin
                    $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
                    errors++;
                end
                if (got.alpha !== want.alpha)
                begin
                    $display("%0t: alpha expected %0d actual %0d", $time, want.alpha,
                             got.alpha);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_factor_settings();
        test_random_stream();
        test_backpressure();
        drain_pipe();
        if (expected_pixels.size() != 0)
            errors++;
        $display("Sent %0d pixels and checked %0d transfers over %0d factor settings.",
                 sent, received, factors_used);
        $display("Mismatches found: %0d.", errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d pixels outstanding.", expected_pixels.size());
        $display("status: fail");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+design
design/rca_pkg.sv
design/rca_if.sv
design/rca_mul.sv
design/rca_cell.sv
design/rca_clamp.sv
design/rgba_contrast_adjust.sv
dv/rgba_contrast_adjust_tb.sv
